// ===== sv/nsc_pkg.sv =====
// Shared types and constants for the NFA subset construction unit.
// Used by the controller, the datapath and the top level; no dependencies.
package nsc_pkg;

  localparam int NfaStates = 3;
  localparam int Symbols   = 2;
  localparam int SetW      = NfaStates;
  localparam int Subsets   = 1 << NfaStates;
  localparam int TableW    = NfaStates * Symbols * NfaStates;
  localparam int SymW      = 1;
  localparam int PtrW      = $clog2(Subsets + 1);
  localparam int IdxW      = $clog2(Subsets);

  // Reset table: 0-a->{0,1}, 0-b->{0}, 1-b->{2}.
  localparam logic [TableW-1:0] TableReset = TableW'(2059);

  typedef enum logic {
    StIdle,
    StWalk
  } nsc_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } nsc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_step;
  } nsc_status_t;

endpackage

// ===== sv/nsc_controller.sv =====
// Sequencer of the NFA subset construction unit.
// Depends on nsc_pkg for the state enum and the command and status structs.
module nsc_controller import nsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  nsc_status_t status_i,
  output nsc_cmd_t    cmd_o
);

  nsc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StWalk;
      end
      StWalk: begin
        if (status_i.out_free && status_i.final_step) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StWalk: begin
        cmd_o.step = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/nsc_datapath.sv =====
// Datapath of the NFA subset construction unit: table register, visited map,
// visit queue, successor logic and output register. Depends on nsc_pkg.
module nsc_datapath import nsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TableW-1:0] cfg_data_i,
  input  logic [SetW-1:0]   start_set_i,
  input  nsc_cmd_t          cmd_i,
  output nsc_status_t       status_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [SetW-1:0]   from_set_o,
  output logic [SymW-1:0]   symbol_index_o,
  output logic [SetW-1:0]   to_set_o,
  output logic              last_o
);

  logic [TableW-1:0]  table_q;
  logic [Subsets-1:0] visited_q, visited_d;
  logic [SetW-1:0]    list_q [Subsets];
  logic [PtrW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [SymW-1:0]    sym_q, sym_d;
  logic               out_valid_q, out_valid_d;
  logic [SetW-1:0]    from_q, to_q;
  logic [SymW-1:0]    osym_q;
  logic               last_q;

  logic [SetW-1:0]    cur_set, succ_set;
  logic               to_new, sym_wrap, final_step;
  logic [PtrW-1:0]    head_nx, tail_nx;

  assign cur_set = list_q[head_q[IdxW-1:0]];

  // Successor is the union of the table rows of the member states.
  always_comb begin
    succ_set = '0;
    for (int s = 0; s < NfaStates; s++) begin
      for (int y = 0; y < Symbols; y++) begin
        if (cur_set[s] && sym_q == SymW'(y)) begin
          succ_set = succ_set | table_q[(s * Symbols + y) * NfaStates +: NfaStates];
        end
      end
    end
  end

  assign to_new     = !visited_q[succ_set] && (tail_q < PtrW'(Subsets));
  assign sym_wrap   = (sym_q == SymW'(Symbols - 1));
  assign head_nx    = sym_wrap ? head_q + PtrW'(1) : head_q;
  assign tail_nx    = to_new ? tail_q + PtrW'(1) : tail_q;
  assign final_step = sym_wrap && (head_nx == tail_nx);

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.final_step = final_step;

  always_comb begin
    visited_d   = visited_q;
    head_d      = head_q;
    tail_d      = tail_q;
    sym_d       = sym_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      visited_d              = '0;
      visited_d[start_set_i] = 1'b1;
      head_d                 = '0;
      tail_d                 = PtrW'(1);
      sym_d                  = '0;
    end else if (cmd_i.step) begin
      if (to_new) visited_d[succ_set] = 1'b1;
      head_d      = head_nx;
      tail_d      = tail_nx;
      sym_d       = sym_wrap ? '0 : sym_q + SymW'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q     <= TableReset;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      sym_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) table_q <= cfg_data_i;
      visited_q   <= visited_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      sym_q       <= sym_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Queue storage and the output word carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      list_q[0] <= start_set_i;
    end else if (cmd_i.step && to_new) begin
      list_q[tail_q[IdxW-1:0]] <= succ_set;
    end
    if (cmd_i.step) begin
      from_q <= cur_set;
      osym_q <= sym_q;
      to_q   <= succ_set;
      last_q <= final_step;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign from_set_o     = from_q;
  assign symbol_index_o = osym_q;
  assign to_set_o       = to_q;
  assign last_o         = last_q;

endmodule

// ===== sv/nfa_subset_construction_unit.sv =====
// Top level of the NFA subset construction unit: controller plus datapath.
// Depends on nsc_pkg, nsc_controller and nsc_datapath.
//
// Each input word names a start subset; the unit walks every subset reachable
// from it breadth first and emits one output word per subset and symbol, with
// last set on the final one. Each item is loaded in a setup step and then walked one
// output word per step by the single successor unit, which forms one transition per
// cycle while the output register is free; a stalled output holds the walk. The
// next item is taken once the last word of the current one sits in the output
// register. The table register may be written at any time the unit is idle.
module nfa_subset_construction_unit import nsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TableW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SetW-1:0]   start_set_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SetW-1:0]   from_set_o,
  output logic [SymW-1:0]   symbol_index_o,
  output logic [SetW-1:0]   to_set_o,
  output logic              last_o
);

  nsc_cmd_t    cmd;
  nsc_status_t status;

  nsc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nsc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .start_set_i    (start_set_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .from_set_o     (from_set_o),
    .symbol_index_o (symbol_index_o),
    .to_set_o       (to_set_o),
    .last_o         (last_o)
  );

endmodule

// ===== sv/nsc_checker.sv =====
// Port-level checks for the NFA subset construction unit, with its bind.
// Depends on the port list of nfa_subset_construction_unit only.
module nsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] from_set_o,
  input logic       symbol_index_o,
  input logic [2:0] to_set_o,
  input logic       last_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(from_set_o)
      && $stable(symbol_index_o) && $stable(to_set_o) && $stable(last_o))
    else $error("stalled output word changed");

  // Once a word is accepted the unit is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // The input only stalls because an item was taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stalled without an accepted word");

  // While a non-final word waits, the walk is still running.
  a_walk_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken before the final word was produced");

  // The final word always describes the last symbol.
  a_last_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> symbol_index_o == 1'b1)
    else $error("final word not on the last symbol");

endmodule

bind nfa_subset_construction_unit nsc_checker u_nsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .from_set_o     (from_set_o),
  .symbol_index_o (symbol_index_o),
  .to_set_o       (to_set_o),
  .last_o         (last_o)
);

// ===== test/nfa_subset_construction_unit_tb.sv =====
// Testbench for nfa_subset_construction_unit: directed and random start subsets
// under several successor tables. Each output word is checked against a behavioral walk.
// Depends on nsc_pkg and the unit's RTL only.
module nfa_subset_construction_unit_tb import nsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 90;

  typedef struct packed {
    logic [SetW-1:0] from_set;
    logic [SymW-1:0] symbol_index;
    logic [SetW-1:0] to_set;
    logic            last;
  } transition_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TableW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SetW-1:0]   start_set_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SetW-1:0]   from_set_o;
  logic [SymW-1:0]   symbol_index_o;
  logic [SetW-1:0]   to_set_o;
  logic              last_o;

  // Behavioral copy of the successor table and the transitions still owed.
  logic [TableW-1:0] nfa_model;
  transition_t       pending_transitions[$];

  bit idle_on     = 1'b1;
  int hold_cycles = 0;
  int error_count = 0;
  int starts_sent = 0;
  int words_seen  = 0;
  int tables_used = 1;
  int cycle_count = 0;

  nfa_subset_construction_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_set_i    (start_set_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .from_set_o     (from_set_o),
    .symbol_index_o (symbol_index_o),
    .to_set_o       (to_set_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_transitions.size());
      $display("nfa_subset_construction_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Breadth-first walk over the subsets reachable from start, one transition
  // per visited subset and symbol, in visit order.
  function automatic void predict_walk(input logic [SetW-1:0] start);
    logic            seen[Subsets];
    logic [SetW-1:0] order[Subsets];
    int              head;
    int              tail;
    logic [SetW-1:0] cur;
    logic [SetW-1:0] nxt;
    transition_t     t;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[start] = 1'b1;
    order[0]    = start;
    head        = 0;
    tail        = 1;
    while (head < tail) begin
      cur = order[head];
      head++;
      for (int y = 0; y < Symbols; y++) begin
        nxt = '0;
        for (int s = 0; s < NfaStates; s++) begin
          if (cur[s]) nxt |= nfa_model[(s * Symbols + y) * NfaStates +: NfaStates];
        end
        t.from_set     = cur;
        t.symbol_index = SymW'(y);
        t.to_set       = nxt;
        t.last         = 1'b0;
        pending_transitions.insert(pending_transitions.size(), t);
        if (!seen[nxt]) begin
          seen[nxt]   = 1'b1;
          order[tail] = nxt;
          tail++;
        end
      end
    end
    pending_transitions[pending_transitions.size() - 1].last = 1'b1;
  endfunction

  // Offers one start subset and returns at the edge where it is taken.
  task automatic send_start_set(input logic [SetW-1:0] start);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_set_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    predict_walk(start);
    starts_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_transitions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_nfa_table(input logic [TableW-1:0] value);
    drain_pipeline();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    nfa_model = value;
    tables_used++;
  endtask

  // Receiver: random stall before each word, or a long hold when one is requested.
  initial begin
    int gap;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    transition_t got;
    transition_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{from_set_o, symbol_index_o, to_set_o, last_o};
      words_seen++;
      if (pending_transitions.size() == 0) begin
        note_failure($sformatf("unexpected word from=%0d sym=%0d to=%0d last=%0d",
                               got.from_set, got.symbol_index, got.to_set, got.last));
      end else begin
        want = pending_transitions[0];
        pending_transitions.delete(0);
        if (got.from_set !== want.from_set || got.symbol_index !== want.symbol_index ||
            got.to_set !== want.to_set || got.last !== want.last) begin
          note_failure($sformatf({"mismatch: expected from=%0d sym=%0d to=%0d last=%0d,",
                                  " got from=%0d sym=%0d to=%0d last=%0d"},
            want.from_set, want.symbol_index, want.to_set, want.last,
            got.from_set, got.symbol_index, got.to_set, got.last));
        end
      end
    end
  end

  // Reset table, every start subset, the empty dead state among them.
  task automatic test_reset_table();
    for (int s = 0; s < Subsets; s++) send_start_set(SetW'(s));
  endtask

  task automatic test_table_extremes();
    load_nfa_table('0);
    send_start_set(3'b000);
    send_start_set(3'b111);
    send_start_set(3'b101);
    load_nfa_table('1);
    send_start_set(3'b001);
    send_start_set(3'b000);
    send_start_set(3'b110);
    // Rotation on one symbol and a growing set on the other reach seven subsets.
    load_nfa_table(18'b100_001_010_100_011_010);
    send_start_set(3'b001);
    send_start_set(3'b100);
    send_start_set(3'b000);
  endtask

  task automatic test_random_tables();
    logic [TableW-1:0] value;
    for (int phase = 0; phase < 6; phase++) begin
      value = TableW'($urandom);
      // Sparse tables make the dead state and short walks more frequent.
      if (phase % 2 == 1) value &= TableW'($urandom) & TableW'($urandom);
      load_nfa_table(value);
      repeat (21) send_start_set(SetW'($urandom_range(0, Subsets - 1)));
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (16) send_start_set(SetW'($urandom_range(0, Subsets - 1)));
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    load_nfa_table(18'b100_001_010_100_011_010);
    idle_on     = 1'b0;
    hold_cycles = HoldCycles;
    repeat (12) send_start_set(SetW'($urandom_range(0, Subsets - 1)));
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    start_set_i <= '0;
    nfa_model = TableReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_table();
    test_table_extremes();
    test_random_tables();
    test_back_to_back();
    test_output_hold();
    drain_pipeline();

    if (pending_transitions.size() != 0) begin
      note_failure($sformatf("%0d words never arrived", pending_transitions.size()));
    end
    $display("%0d start subsets walked under %0d successor tables, %0d words checked",
             starts_sent, tables_used, words_seen);
    $display("%0d failures, back-to-back and long output hold phases included", error_count);
    if (error_count == 0) begin
      $display("nfa_subset_construction_unit_tb: done, clean");
    end else begin
      $display("nfa_subset_construction_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
